[rtl/dcae_pkg.sv]
// ----------------------------------------------------------------------------
// dcae_pkg
// Shared widths, limits, register indexes and reset values of the
// daisy-chain address enumerator.
// ----------------------------------------------------------------------------
package dcae_pkg;

	// Width of the address counter and of the tick timer.
	localparam int ADDR_WIDTH  = 8;
	localparam int TIMER_WIDTH = 24;

	// Width of the counter of edges sent upward: it reaches 2*address+1.
	localparam int EDGE_WIDTH = ADDR_WIDTH + 1;

	localparam logic [ADDR_WIDTH-1:0]  ADDR_MAX  = {ADDR_WIDTH{1'b1}};
	localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

	// Configuration port.
	localparam int CFG_INDEX_WIDTH = 4;
	localparam int CFG_DATA_WIDTH  = 24;

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STARTUP_TIMEOUT = 4'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PULSE_GAP       = 4'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TOGGLE_HALF     = 4'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_REPLY_TIMEOUT   = 4'd3;

	// Register reset values.
	localparam logic [23:0] STARTUP_TIMEOUT_RESET = 24'd100000;
	localparam logic [15:0] PULSE_GAP_RESET       = 16'd500;
	localparam logic [15:0] TOGGLE_HALF_RESET     = 16'd100;
	localparam logic [15:0] REPLY_TIMEOUT_RESET   = 16'd500;

	// Address taken by the unit at the bottom of the chain.
	localparam logic [ADDR_WIDTH-1:0] BOTTOM_ADDRESS = ADDR_WIDTH'(8'h01);

endpackage

[rtl/daisy_chain_address_enumerator_core.sv]
// ----------------------------------------------------------------------------
// daisy_chain_address_enumerator_core
// Daisy-chain address enumerator: counts pulses from the unit below, then
// passes address+1 pulses to the unit above and waits for its reply.
// ----------------------------------------------------------------------------
// Path: an input transfer passes the input register, then the state update into
// the result register, before its result appears.
// Throughput: one tick item per cycle while the output does not stall.
// The input stalls only while a finished result is held by output stall.
// Reset (arst_n low, asynchronous): start-wait phase, address zero, up pin
// level register high but the up pin not driven, configuration registers back to their default tick counts.
// ----------------------------------------------------------------------------
module daisy_chain_address_enumerator_core
	import dcae_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,

	// Tick items in.
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       down_level,
	input  logic                       up_level,

	// Pin controls and status out.
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       down_drive_enable,
	output logic                       down_drive_value,
	output logic                       up_drive_enable,
	output logic                       up_drive_value,
	output logic                       up_pull_select,
	output logic [7:0]                 chain_address,
	output logic [2:0]                 phase_now,
	output logic                       finished,

	// Configuration writes.
	input  logic                       wr_en,
	input  logic [CFG_INDEX_WIDTH-1:0] wr_index,
	input  logic [CFG_DATA_WIDTH-1:0]  wr_data
);

	// The phase codes are visible on phase_now, so the encoding is fixed.
	typedef enum logic [2:0] {
		PH_START     = 3'd0,
		PH_COUNT     = 3'd1,
		PH_SEND      = 3'd2,
		PH_WAIT_RISE = 3'd3,
		PH_WAIT_FALL = 3'd4,
		PH_DONE      = 3'd5
	} phase_t;

	// Configuration registers.
	logic [23:0] startup_timeout_q;
	logic [15:0] pulse_gap_q;
	logic [15:0] toggle_half_q;
	logic [15:0] reply_timeout_q;

	// Input register stage.
	logic valid_s1;
	logic down_s1;
	logic up_s1;

	// Enumeration state.
	phase_t                 phase_q;
	logic [ADDR_WIDTH-1:0]  addr_q;
	logic [EDGE_WIDTH-1:0]  edges_q;
	logic [TIMER_WIDTH-1:0] timer_q;
	logic                   last_down_q;
	logic                   last_up_q;
	logic                   up_pin_q;
	logic                   startup_fired_q;
	logic                   pull_up_q;

	// Result register valid.
	logic out_valid_q;

	// Next state.
	phase_t                 phase_n;
	logic [ADDR_WIDTH-1:0]  addr_n;
	logic [EDGE_WIDTH-1:0]  edges_n;
	logic [TIMER_WIDTH-1:0] timer_n;
	logic                   up_pin_n;
	logic                   startup_fired_n;
	logic                   pull_up_n;

	logic                   fall_down;
	logic                   rise_up;
	logic [TIMER_WIDTH-1:0] timer_inc;
	logic [TIMER_WIDTH-1:0] limit;
	logic                   expired;
	logic [EDGE_WIDTH-1:0]  edges_inc;
	logic                   advance;

	// Next result fields.
	logic dn_en_n;
	logic dn_val_n;
	logic up_en_n;

	// A limit above what the timer can count is clipped to the timer maximum.
	function automatic logic [TIMER_WIDTH-1:0] clip_limit(input logic [23:0] value);
		logic [31:0] wide;
		wide = 32'(value);
		if (wide > 32'(TIMER_MAX)) begin
			return TIMER_MAX;
		end
		return TIMER_WIDTH'(wide);
	endfunction

	// The whole pipeline moves unless a result is held at the output.
	assign advance  = !(out_valid_q && out_stall);
	assign in_stall = !advance;
	assign out_valid = out_valid_q;

	// Configuration writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			startup_timeout_q <= STARTUP_TIMEOUT_RESET;
			pulse_gap_q       <= PULSE_GAP_RESET;
			toggle_half_q     <= TOGGLE_HALF_RESET;
			reply_timeout_q   <= REPLY_TIMEOUT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				CFG_STARTUP_TIMEOUT: startup_timeout_q <= wr_data[23:0];
				CFG_PULSE_GAP:       pulse_gap_q       <= wr_data[15:0];
				CFG_TOGGLE_HALF:     toggle_half_q     <= wr_data[15:0];
				CFG_REPLY_TIMEOUT:   reply_timeout_q   <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	// Next-state logic for one tick held in the input register.
	always_comb begin
		phase_n         = phase_q;
		addr_n          = addr_q;
		edges_n         = edges_q;
		timer_n         = timer_q;
		up_pin_n        = up_pin_q;
		startup_fired_n = startup_fired_q;
		pull_up_n       = pull_up_q;

		fall_down = last_down_q && !down_s1;
		rise_up   = !last_up_q && up_s1;

		// The timer saturates rather than wrapping, and it expires on the
		// tick on which it reaches the limit of the current phase.
		timer_inc = (timer_q != TIMER_MAX) ? timer_q + 1'b1 : TIMER_MAX;
		case (phase_q)
			PH_START:     limit = clip_limit(startup_timeout_q);
			PH_COUNT:     limit = clip_limit(24'(pulse_gap_q));
			PH_SEND:      limit = clip_limit(24'(toggle_half_q));
			PH_WAIT_RISE: limit = clip_limit(24'(reply_timeout_q));
			default:      limit = '0;
		endcase
		expired   = (timer_inc >= limit);
		edges_inc = edges_q + 1'b1;

		case (phase_q)
			PH_START: begin
				if (fall_down) begin
					addr_n  = (addr_q != ADDR_MAX) ? addr_q + 1'b1 : ADDR_MAX;
					timer_n = '0;
					phase_n = PH_COUNT;
				end else if (!startup_fired_q) begin
					timer_n = timer_inc;
					if (expired) begin
						// The start-up check is one-shot. With the down pin
						// high the block keeps waiting for edges forever.
						startup_fired_n = 1'b1;
						if (!down_s1 && addr_q == '0) begin
							addr_n   = BOTTOM_ADDRESS;
							phase_n  = PH_SEND;
							up_pin_n = 1'b0;
							edges_n  = EDGE_WIDTH'(1);
							timer_n  = '0;
						end
					end
				end
			end
			PH_COUNT: begin
				// An edge wins over a gap timeout on the same tick.
				if (fall_down) begin
					addr_n  = (addr_q != ADDR_MAX) ? addr_q + 1'b1 : ADDR_MAX;
					timer_n = '0;
				end else begin
					timer_n = timer_inc;
					if (expired) begin
						phase_n  = PH_SEND;
						up_pin_n = 1'b0;
						edges_n  = EDGE_WIDTH'(1);
						timer_n  = '0;
					end
				end
			end
			PH_SEND: begin
				timer_n = timer_inc;
				if (expired) begin
					up_pin_n = !up_pin_q;
					edges_n  = edges_inc;
					timer_n  = '0;
					// 2*address+1 edges give address+1 falling edges.
					if (edges_inc >= {addr_q, 1'b1}) begin
						phase_n   = PH_WAIT_RISE;
						pull_up_n = 1'b0;
					end
				end
			end
			PH_WAIT_RISE: begin
				if (rise_up) begin
					phase_n   = PH_WAIT_FALL;
					pull_up_n = 1'b1;
					timer_n   = '0;
				end else begin
					timer_n = timer_inc;
					if (expired) begin
						phase_n = PH_DONE;
						timer_n = '0;
					end
				end
			end
			PH_WAIT_FALL: begin
				// Any low sample finishes, whether already low or just fallen.
				if (!up_s1) begin
					phase_n = PH_DONE;
					timer_n = '0;
				end
			end
			default: ;
		endcase

		dn_en_n  = (phase_n >= PH_SEND);
		dn_val_n = (phase_n >= PH_SEND) && (phase_n <= PH_WAIT_FALL);
		up_en_n  = (phase_n <= PH_SEND);
	end

	// State and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1          <= 1'b0;
			down_s1           <= 1'b0;
			up_s1             <= 1'b0;
			phase_q           <= PH_START;
			addr_q            <= '0;
			edges_q           <= '0;
			timer_q           <= '0;
			last_down_q       <= 1'b0;
			last_up_q         <= 1'b0;
			up_pin_q          <= 1'b1;
			startup_fired_q   <= 1'b0;
			pull_up_q         <= 1'b0;
			out_valid_q       <= 1'b0;
			down_drive_enable <= 1'b0;
			down_drive_value  <= 1'b0;
			up_drive_enable   <= 1'b0;
			up_drive_value    <= 1'b0;
			up_pull_select    <= 1'b0;
			chain_address     <= '0;
			phase_now         <= '0;
			finished          <= 1'b0;
		end else if (advance) begin
			valid_s1    <= in_valid;
			down_s1     <= down_level;
			up_s1       <= up_level;
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				phase_q           <= phase_n;
				addr_q            <= addr_n;
				edges_q           <= edges_n;
				timer_q           <= timer_n;
				last_down_q       <= down_s1;
				last_up_q         <= up_s1;
				up_pin_q          <= up_pin_n;
				startup_fired_q   <= startup_fired_n;
				pull_up_q         <= pull_up_n;
				down_drive_enable <= dn_en_n;
				down_drive_value  <= dn_val_n;
				up_drive_enable   <= up_en_n;
				up_drive_value    <= up_en_n && up_pin_n;
				up_pull_select    <= !up_en_n && pull_up_n;
				chain_address     <= 8'(addr_n);
				phase_now         <= 3'(phase_n);
				finished          <= (phase_n == PH_DONE);
			end
		end
	end

	// Done holds until reset.
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |=> phase_q == PH_DONE)
		else $error("enumerator left the done phase");

	// While sending, the edge count never runs past 2*address+1.
	a_edges_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SEND |-> edges_q <= {addr_q, 1'b1})
		else $error("edge count exceeded 2*address+1");

	// Every phase from sending onward has a known, nonzero address.
	a_addr_known: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q >= PH_SEND |-> addr_q != '0)
		else $error("enumeration past counting with address zero");

endmodule
